>>> design/fpas_pkg.sv
// shared types and constants for the format spec pointer argument scanner
// no dependencies; imported by every module of the block
package fpas_pkg;

    // width of the position counters and digit runs
    localparam int POS_W = 16;

    // configuration register indexes
    localparam logic [1:0] REG_INT_BYTES       = 2'd0;
    localparam logic [1:0] REG_SHORT_BYTES     = 2'd1;
    localparam logic [1:0] REG_LONG_BYTES      = 2'd2;
    localparam logic [1:0] REG_LONG_LONG_BYTES = 2'd3;

    // length modifier codes
    localparam logic [1:0] MOD_NONE      = 2'd0;
    localparam logic [1:0] MOD_SHORT     = 2'd1;
    localparam logic [1:0] MOD_LONG      = 2'd2;
    localparam logic [1:0] MOD_LONG_LONG = 2'd3;

    // result kinds
    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [3:0] int_bytes;
        logic [3:0] short_bytes;
        logic [3:0] long_bytes;
        logic [3:0] long_long_bytes;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] arg_position;
        logic [3:0]  elem_bytes;
        logic        mixed_warning;
        logic        malformed;
        logic        run_end;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

>>> design/format_spec_pointer_arg_scanner.sv
// top level of the printf format string scanner reporting %n pointer targets
// depends on fpas_pkg, fpas_cfg, fpas_scan, fpas_outq
//
// channel   dir  width  contents
// s_axis    in   8+1    tdata ch, tlast last
// m_axis    out  24+1+1 tdata position/bytes/flags, tuser kind, tlast run_end
// apb       in   4 addr four 4-bit size registers at 0x0, 0x4, 0x8, 0xc
//
// one character per cycle while the queue has room; an item is held in the input
// register, where the whole phase chain for that character is resolved, then lands in
// the result queue. a character may give two results (record and summary); the queue
// drains one a cycle if m_tready is high; the input stalls while fewer than two queue
// entries are free. reset clears scanner state and restores the register defaults.
module format_spec_pointer_arg_scanner
    import fpas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] arg_position, [19:16] elem_bytes,
                                   // [20] mixed_warning, [21] malformed
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    push_t   push;
    logic    room;
    result_t res;

    fpas_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpas_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ch    (s_tdata),
        .in_last  (s_tlast),
        .cfg      (cfg),
        .room     (room),
        .push     (push)
    );

    fpas_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {2'b00, res.malformed, res.mixed_warning, res.elem_bytes,
                      res.arg_position};
    assign m_tuser = res.kind;
    assign m_tlast = res.run_end;

endmodule

>>> design/fpas_cfg.sv
// configuration registers behind the apb-style port
// depends on fpas_pkg
module fpas_cfg
    import fpas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic [3:0] rd_val;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_INT_BYTES:       cfg_next.int_bytes       = pwdata[3:0];
                REG_SHORT_BYTES:     cfg_next.short_bytes     = pwdata[3:0];
                REG_LONG_BYTES:      cfg_next.long_bytes      = pwdata[3:0];
                REG_LONG_LONG_BYTES: cfg_next.long_long_bytes = pwdata[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_INT_BYTES:       rd_val = cfg_reg.int_bytes;
            REG_SHORT_BYTES:     rd_val = cfg_reg.short_bytes;
            REG_LONG_BYTES:      rd_val = cfg_reg.long_bytes;
            REG_LONG_LONG_BYTES: rd_val = cfg_reg.long_long_bytes;
            default:             rd_val = 4'd0;
        endcase
    end

    assign prdata = {28'd0, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.int_bytes       <= 4'd4;
            cfg_reg.short_bytes     <= 4'd2;
            cfg_reg.long_bytes      <= 4'd8;
            cfg_reg.long_long_bytes <= 4'd8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/fpas_scan.sv
// input register and single-pass spec scanner; produces up to two results per item
// depends on fpas_pkg
module fpas_scan
    import fpas_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_ch,
    input  logic       in_last,
    input  cfg_t       cfg,
    input  logic       room,
    output push_t      push
);

    typedef enum logic [3:0] {
        PH_TEXT, PH_PCT, PH_POS_ZERO, PH_POS_RUN, PH_FLAG, PH_WIDTH, PH_WIDTH_DIG,
        PH_PREC, PH_DOT, PH_PREC_DIG, PH_STAR, PH_STAR_RUN, PH_MOD, PH_MOD2, PH_CONV
    } phase_t;

    typedef struct packed {
        phase_t     ph;
        logic       star;
        logic [1:0] md;
        logic       again;
        logic       tp;
        logic       pos_load;
        logic       seen_pos;
        logic       dload;
        logic       dadd;
        logic       emit;
    } step_t;

    // longest chain of re-examined phases for one character is six
    localparam int STEPS = 8;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    function automatic logic is_digit(logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_flag(logic [7:0] c);
        return (c == 8'h2D) || (c == 8'h2B) || (c == 8'h20) || (c == 8'h23) ||
               (c == 8'h30);
    endfunction

    function automatic step_t step_once(phase_t ph, logic star, logic [1:0] md,
                                        logic [7:0] c, logic dnz);
        step_t s;
        s          = '0;
        s.ph       = ph;
        s.star     = star;
        s.md       = md;
        unique case (ph)
            PH_TEXT:
            begin
                if (c == 8'h25) s.ph = PH_PCT;
            end
            PH_PCT:
            begin
                s.md = MOD_NONE;
                if (is_digit(c))
                begin
                    s.dload = 1'b1;
                    s.ph    = (c == 8'h30) ? PH_POS_ZERO : PH_POS_RUN;
                end
                else
                begin
                    s.tp    = 1'b1;
                    s.ph    = PH_FLAG;
                    s.again = 1'b1;
                end
            end
            PH_POS_ZERO, PH_POS_RUN:
            begin
                if (is_digit(c))
                begin
                    s.dadd = 1'b1;
                    s.ph   = PH_POS_RUN;
                end
                else if (c == 8'h24)
                begin
                    if (dnz)
                    begin
                        s.seen_pos = 1'b1;
                        s.pos_load = 1'b1;
                    end
                    else
                    begin
                        s.tp = 1'b1;
                    end
                    s.ph = PH_FLAG;
                end
                else
                begin
                    s.tp    = 1'b1;
                    s.ph    = (ph == PH_POS_ZERO) ? PH_WIDTH : PH_PREC;
                    s.again = 1'b1;
                end
            end
            PH_FLAG:
            begin
                s.ph    = PH_WIDTH;
                s.again = !is_flag(c);
            end
            PH_WIDTH:
            begin
                if (c == 8'h2A)
                begin
                    s.ph   = PH_STAR;
                    s.star = 1'b0;
                end
                else if (is_digit(c))
                begin
                    s.ph = PH_WIDTH_DIG;
                end
                else
                begin
                    s.ph    = PH_PREC;
                    s.again = 1'b1;
                end
            end
            PH_WIDTH_DIG:
            begin
                if (!is_digit(c))
                begin
                    s.ph    = PH_PREC;
                    s.again = 1'b1;
                end
            end
            PH_PREC:
            begin
                if (c == 8'h2E)
                begin
                    s.ph = PH_DOT;
                end
                else
                begin
                    s.ph    = PH_MOD;
                    s.again = 1'b1;
                end
            end
            PH_DOT:
            begin
                if (c == 8'h2A)
                begin
                    s.ph   = PH_STAR;
                    s.star = 1'b1;
                end
                else if (is_digit(c))
                begin
                    s.ph = PH_PREC_DIG;
                end
                else
                begin
                    s.ph    = PH_MOD;
                    s.again = 1'b1;
                end
            end
            PH_PREC_DIG:
            begin
                if (!is_digit(c))
                begin
                    s.ph    = PH_MOD;
                    s.again = 1'b1;
                end
            end
            PH_STAR:
            begin
                if (is_digit(c))
                begin
                    s.dload = 1'b1;
                    s.ph    = PH_STAR_RUN;
                end
                else
                begin
                    s.tp    = 1'b1;
                    s.ph    = star ? PH_MOD : PH_PREC;
                    s.again = 1'b1;
                end
            end
            PH_STAR_RUN:
            begin
                if (is_digit(c))
                begin
                    s.dadd = 1'b1;
                end
                else if (c == 8'h24)
                begin
                    if (dnz) s.seen_pos = 1'b1;
                    else     s.tp       = 1'b1;
                    s.ph = star ? PH_MOD : PH_PREC;
                end
                else
                begin
                    // run was a conversion; the ending character is text again
                    s.tp    = 1'b1;
                    s.ph    = PH_TEXT;
                    s.again = 1'b1;
                end
            end
            PH_MOD:
            begin
                if (c == 8'h68)
                begin
                    s.md = MOD_SHORT;
                    s.ph = PH_MOD2;
                end
                else if (c == 8'h6C)
                begin
                    s.md = MOD_LONG;
                    s.ph = PH_MOD2;
                end
                else if (c == 8'h4C)
                begin
                    s.md = MOD_LONG_LONG;
                    s.ph = PH_CONV;
                end
                else
                begin
                    s.ph    = PH_CONV;
                    s.again = 1'b1;
                end
            end
            PH_MOD2:
            begin
                if (md == MOD_SHORT && c == 8'h68)
                begin
                    s.md = MOD_NONE;
                    s.ph = PH_CONV;
                end
                else if (md == MOD_LONG && c == 8'h6C)
                begin
                    s.md = MOD_LONG_LONG;
                    s.ph = PH_CONV;
                end
                else
                begin
                    s.ph    = PH_CONV;
                    s.again = 1'b1;
                end
            end
            PH_CONV:
            begin
                s.emit = (c == 8'h6E);
                s.ph   = PH_TEXT;
            end
            default:
            begin
                s.ph = PH_TEXT;
            end
        endcase
        return s;
    endfunction

    function automatic logic [15:0] sat16(logic [POS_W-1:0] v);
        logic [POS_W+15:0] ext;
        ext = {16'd0, v};
        if (ext > {{POS_W{1'b0}}, 16'hFFFF})
            return 16'hFFFF;
        return ext[15:0];
    endfunction

    logic             in_valid_reg;
    logic [7:0]       ch_reg;
    logic             last_reg;
    phase_t           phase_reg, phase_next;
    logic             star_reg, star_next;
    logic [1:0]       mod_reg, mod_next;
    logic [POS_W-1:0] digit_reg, digit_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             seen_pos_reg, seen_pos_next;
    logic             seen_plain_reg, seen_plain_next;

    logic             advance;
    step_t            st;
    phase_t           cur_ph;
    logic             cur_star;
    logic [1:0]       cur_md;
    logic             active;
    logic             f_tp, f_pos_load, f_seen_pos, f_dload, f_dadd, f_emit;
    logic             tp_total;
    logic             bad;
    logic             sp_f, spl_f;
    logic [POS_W+3:0] dsum;
    logic [POS_W-1:0] pos_upd;
    logic [3:0]       elem;
    result_t          rec, summ;

    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || advance;

    // walk the chained phase transitions for the held character
    always_comb
    begin
        cur_ph     = phase_reg;
        cur_star   = star_reg;
        cur_md     = mod_reg;
        active     = 1'b1;
        f_tp       = 1'b0;
        f_pos_load = 1'b0;
        f_seen_pos = 1'b0;
        f_dload    = 1'b0;
        f_dadd     = 1'b0;
        f_emit     = 1'b0;
        st         = '0;
        for (int i = 0; i < STEPS; i++)
        begin
            if (active)
            begin
                st         = step_once(cur_ph, cur_star, cur_md, ch_reg, digit_reg != '0);
                cur_ph     = st.ph;
                cur_star   = st.star;
                cur_md     = st.md;
                f_tp       = f_tp | st.tp;
                f_pos_load = f_pos_load | st.pos_load;
                f_seen_pos = f_seen_pos | st.seen_pos;
                f_dload    = f_dload | st.dload;
                f_dadd     = f_dadd | st.dadd;
                f_emit     = f_emit | st.emit;
                active     = st.again;
            end
        end
    end

    always_comb
    begin
        // times ten as two shifts, plus the digit (low nibble of an ascii digit)
        dsum = ({4'd0, digit_reg} << 3) + ({4'd0, digit_reg} << 1) +
               {{POS_W{1'b0}}, ch_reg[3:0]};
        if (f_dload)
            digit_next = {{(POS_W-4){1'b0}}, ch_reg[3:0]};
        else if (f_dadd)
            digit_next = (dsum > {4'd0, POS_MAX}) ? POS_MAX : dsum[POS_W-1:0];
        else
            digit_next = digit_reg;

        // a string ending inside a star run closes it as a plain argument
        tp_total = f_tp || (last_reg && cur_ph == PH_STAR_RUN);
        pos_upd  = f_pos_load ? digit_reg : pos_reg;
        if (tp_total && pos_upd != POS_MAX)
            pos_upd = pos_upd + 1'b1;

        sp_f  = seen_pos_reg || f_seen_pos;
        spl_f = seen_plain_reg || tp_total;
        bad   = !(cur_ph == PH_TEXT || cur_ph == PH_STAR_RUN);

        case (cur_md)
            MOD_SHORT:     elem = cfg.short_bytes;
            MOD_LONG:      elem = cfg.long_bytes;
            MOD_LONG_LONG: elem = cfg.long_long_bytes;
            default:       elem = cfg.int_bytes;
        endcase

        rec.kind          = KIND_RECORD;
        rec.arg_position  = sat16(pos_upd);
        rec.elem_bytes    = elem;
        rec.mixed_warning = 1'b0;
        rec.malformed     = 1'b0;
        rec.run_end       = !last_reg;

        summ.kind          = KIND_SUMMARY;
        summ.arg_position  = 16'd0;
        summ.elem_bytes    = 4'd0;
        summ.mixed_warning = !bad && sp_f && spl_f;
        summ.malformed     = bad;
        summ.run_end       = 1'b1;

        push.res0 = f_emit ? rec : summ;
        push.res1 = summ;
        push.cnt  = advance ? ({1'b0, f_emit} + {1'b0, last_reg}) : 2'd0;

        if (last_reg)
        begin
            phase_next      = PH_TEXT;
            star_next       = 1'b0;
            mod_next        = MOD_NONE;
            pos_next        = '0;
            seen_pos_next   = 1'b0;
            seen_plain_next = 1'b0;
            digit_next      = '0;
        end
        else
        begin
            phase_next      = cur_ph;
            star_next       = cur_star;
            mod_next        = cur_md;
            pos_next        = pos_upd;
            seen_pos_next   = sp_f;
            seen_plain_next = spl_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            ch_reg         <= 8'd0;
            last_reg       <= 1'b0;
            phase_reg      <= PH_TEXT;
            star_reg       <= 1'b0;
            mod_reg        <= MOD_NONE;
            digit_reg      <= '0;
            pos_reg        <= '0;
            seen_pos_reg   <= 1'b0;
            seen_plain_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
                ch_reg       <= in_ch;
                last_reg     <= in_last;
            end
            if (advance)
            begin
                phase_reg      <= phase_next;
                star_reg       <= star_next;
                mod_reg        <= mod_next;
                digit_reg      <= digit_next;
                pos_reg        <= pos_next;
                seen_pos_reg   <= seen_pos_next;
                seen_plain_reg <= seen_plain_next;
            end
        end
    end

endmodule

>>> design/fpas_outq.sv
// four-entry result queue: up to two in per cycle, one out per cycle when ready
// depends on fpas_pkg
module fpas_outq
    import fpas_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   head_reg, tail_reg;
    logic [AW:0]     count_reg, count_next;
    logic            pop;
    logic [AW-1:0]   tail1;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[head_reg];
    // two free entries needed before the scanner may advance
    assign room      = count_reg <= (AW+1)'(DEPTH - 2);
    assign tail1     = tail_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg + {{(AW-1){1'b0}}, push.cnt} - {{AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[tail_reg] <= push.res0;
        if (push.cnt == 2'd2)
            mem_reg[tail1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            tail_reg  <= tail_reg + push.cnt[AW-1:0];
            if (pop)
                head_reg <= head_reg + 1'b1;
        end
    end

endmodule

>>> tb/sv/scan_result_checker.sv
// scoreboard for the format spec scanner: watches the input, result and register channels
// depends on fpas_pkg; predicts the %n records and string summaries and compares them in order
module scan_result_checker
    import fpas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [15:0] arg_position, [19:16] elem_bytes,
                                   // [20] mixed_warning, [21] malformed
    input  logic        m_tuser,   // [0] kind
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [3:0] {
        S_TEXT, S_PCT, S_POS_ZERO, S_POS_RUN, S_FLAG, S_WIDTH, S_WIDTH_DIG,
        S_PREC, S_DOT, S_PREC_DIG, S_STAR, S_STAR_RUN, S_MOD, S_MOD2, S_CONV
    } spec_phase_t;

    cfg_t             sizes;
    spec_phase_t      phase;
    logic             star_in_prec;
    logic [POS_W-1:0] digit_val;
    logic [POS_W-1:0] cur_pos;
    logic [1:0]       mod_code;
    logic             seen_pos;
    logic             seen_plain;

    result_t pointer_results[$];
    result_t got;
    result_t want;

    function automatic void clear_spec_state();
        phase        = S_TEXT;
        star_in_prec = 1'b0;
        digit_val    = '0;
        cur_pos      = '0;
        mod_code     = MOD_NONE;
        seen_pos     = 1'b0;
        seen_plain   = 1'b0;
    endfunction

    // a spec without an explicit position takes the next argument
    function automatic void take_plain();
        seen_plain = 1'b1;
        if (cur_pos != POS_MAX)
            cur_pos++;
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        logic [31:0] v;
        v = 32'(digit_val) * 32'd10 + 32'(c - "0");
        digit_val = (v > 32'(POS_MAX)) ? POS_MAX : v[POS_W-1:0];
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("kind=%0d pos=%0d bytes=%0d mixed=%0d malformed=%0d end=%0d",
                         r.kind, r.arg_position, r.elem_bytes, r.mixed_warning,
                         r.malformed, r.run_end);
    endfunction

    task automatic scan_char(input logic [7:0] c, input logic last);
        result_t res [2];
        int      n;
        logic    again;
        logic    dig;
        logic    bad;
        n = 0;
        dig = (c >= "0") && (c <= "9");
        // one character may walk through several phases before it is consumed
        do
        begin
            again = 1'b0;
            case (phase)
                S_TEXT:
                    if (c == "%")
                        phase = S_PCT;
                S_PCT:
                begin
                    mod_code = MOD_NONE;
                    if (dig)
                    begin
                        digit_val = POS_W'(c - "0");
                        phase = (c == "0") ? S_POS_ZERO : S_POS_RUN;
                    end
                    else
                    begin
                        take_plain();
                        phase = S_FLAG;
                        again = 1'b1;
                    end
                end
                S_POS_ZERO, S_POS_RUN:
                begin
                    if (dig)
                    begin
                        add_digit(c);
                        phase = S_POS_RUN;
                    end
                    else if (c == "$")
                    begin
                        // all-zero position counts as a plain spec
                        if (digit_val != 0)
                        begin
                            seen_pos = 1'b1;
                            cur_pos = digit_val;
                        end
                        else
                            take_plain();
                        phase = S_FLAG;
                    end
                    else
                    begin
                        // lone leading zero was a flag, any other digit run was a width
                        take_plain();
                        phase = (phase == S_POS_ZERO) ? S_WIDTH : S_PREC;
                        again = 1'b1;
                    end
                end
                S_FLAG:
                begin
                    phase = S_WIDTH;
                    again = !(c == "-" || c == "+" || c == " " || c == "#" || c == "0");
                end
                S_WIDTH:
                    if (c == "*")
                    begin
                        phase = S_STAR;
                        star_in_prec = 1'b0;
                    end
                    else if (dig)
                        phase = S_WIDTH_DIG;
                    else
                    begin
                        phase = S_PREC;
                        again = 1'b1;
                    end
                S_WIDTH_DIG:
                    if (!dig)
                    begin
                        phase = S_PREC;
                        again = 1'b1;
                    end
                S_PREC:
                    if (c == ".")
                        phase = S_DOT;
                    else
                    begin
                        phase = S_MOD;
                        again = 1'b1;
                    end
                S_DOT:
                    if (c == "*")
                    begin
                        phase = S_STAR;
                        star_in_prec = 1'b1;
                    end
                    else if (dig)
                        phase = S_PREC_DIG;
                    else
                    begin
                        phase = S_MOD;
                        again = 1'b1;
                    end
                S_PREC_DIG:
                    if (!dig)
                    begin
                        phase = S_MOD;
                        again = 1'b1;
                    end
                S_STAR:
                    if (dig)
                    begin
                        digit_val = POS_W'(c - "0");
                        phase = S_STAR_RUN;
                    end
                    else
                    begin
                        take_plain();
                        phase = star_in_prec ? S_MOD : S_PREC;
                        again = 1'b1;
                    end
                S_STAR_RUN:
                    if (dig)
                        add_digit(c);
                    else if (c == "$")
                    begin
                        if (digit_val != 0)
                            seen_pos = 1'b1;
                        else
                            take_plain();
                        phase = star_in_prec ? S_MOD : S_PREC;
                    end
                    else
                    begin
                        // run without '$': spec already ended at its first digit
                        take_plain();
                        phase = S_TEXT;
                        again = 1'b1;
                    end
                S_MOD:
                    if (c == "h")
                    begin
                        mod_code = MOD_SHORT;
                        phase = S_MOD2;
                    end
                    else if (c == "l")
                    begin
                        mod_code = MOD_LONG;
                        phase = S_MOD2;
                    end
                    else if (c == "L")
                    begin
                        mod_code = MOD_LONG_LONG;
                        phase = S_CONV;
                    end
                    else
                    begin
                        phase = S_CONV;
                        again = 1'b1;
                    end
                S_MOD2:
                    if (mod_code == MOD_SHORT && c == "h")
                    begin
                        mod_code = MOD_NONE;
                        phase = S_CONV;
                    end
                    else if (mod_code == MOD_LONG && c == "l")
                    begin
                        mod_code = MOD_LONG_LONG;
                        phase = S_CONV;
                    end
                    else
                    begin
                        phase = S_CONV;
                        again = 1'b1;
                    end
                default:
                begin
                    if (c == "n" && n < 2)
                    begin
                        res[n] = '0;
                        res[n].kind = KIND_RECORD;
                        res[n].arg_position = cur_pos;
                        case (mod_code)
                            MOD_SHORT:     res[n].elem_bytes = sizes.short_bytes;
                            MOD_LONG:      res[n].elem_bytes = sizes.long_bytes;
                            MOD_LONG_LONG: res[n].elem_bytes = sizes.long_long_bytes;
                            default:       res[n].elem_bytes = sizes.int_bytes;
                        endcase
                        n++;
                    end
                    phase = S_TEXT;
                end
            endcase
        end
        while (again);

        if (last)
        begin
            if (phase == S_STAR_RUN)
                take_plain();
            bad = !(phase == S_TEXT || phase == S_STAR_RUN);
            res[n] = '0;
            res[n].kind = KIND_SUMMARY;
            res[n].mixed_warning = !bad && seen_pos && seen_plain;
            res[n].malformed = bad;
            n++;
            clear_spec_state();
        end
        if (n > 0)
            res[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            pointer_results.push_back(res[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_spec_state();
            sizes.int_bytes       = 4'd4;
            sizes.short_bytes     = 4'd2;
            sizes.long_bytes      = 4'd8;
            sizes.long_long_bytes = 4'd8;
            pointer_results.delete();
            pending = 0;
        end
        else
        begin
            // a result can never stem from the item taken at this same edge
            if (m_tvalid && m_tready)
            begin
                got = '0;
                got.kind          = m_tuser;
                got.arg_position  = m_tdata[15:0];
                got.elem_bytes    = m_tdata[19:16];
                got.mixed_warning = m_tdata[20];
                got.malformed     = m_tdata[21];
                got.run_end       = m_tlast;
                if (pointer_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected item: expected none, actual %s",
                             $time, show(got));
                end
                else
                begin
                    want = pointer_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t ns: mismatch: expected %s, actual %s",
                                 $time, show(want), show(got));
                    end
                end
            end
            if (psel && penable && pwrite && pready)
                case (paddr[3:2])
                    REG_INT_BYTES:       sizes.int_bytes       = pwdata[3:0];
                    REG_SHORT_BYTES:     sizes.short_bytes     = pwdata[3:0];
                    REG_LONG_BYTES:      sizes.long_bytes      = pwdata[3:0];
                    REG_LONG_LONG_BYTES: sizes.long_long_bytes = pwdata[3:0];
                    default: ;
                endcase
            if (s_tvalid && s_tready)
                scan_char(s_tdata, s_tlast);
            pending = pointer_results.size();
        end
    end

endmodule

>>> tb/sv/format_spec_pointer_arg_scanner_tb.sv
// testbench top for the format spec scanner: clock, reset, format strings and size registers
// depends on fpas_pkg, the scanner RTL and scan_result_checker, which checks the results
module format_spec_pointer_arg_scanner_tb
    import fpas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] ch
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] arg_position, [19:16] elem_bytes,
                            // [20] mixed_warning, [21] malformed
    logic        m_tuser;   // [0] kind
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int cycle_cnt;
    bit calm;
    bit hold_go;

    logic [7:0] fmt_chars[$];

    format_spec_pointer_arg_scanner dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    scan_result_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .pready(pready),
        .mismatches(mismatches), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("FAIL format_spec_pointer_arg_scanner");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            fmt_chars.push_back(s[i]);
    endfunction

    function automatic void push_num(input int unsigned v);
        push_str($sformatf("%0d", v));
    endfunction

    // argument position digits: mostly small, some zero, some that saturate
    function automatic void push_position();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            push_num($urandom_range(1, 12));
        else if (r < 80)
            push_str(r < 75 ? "0" : "00");
        else if (r < 90)
            push_num($urandom_range(65530, 99999999));
        else
            push_num($urandom());
    endfunction

    function automatic void push_spec();
        string flags;
        string convs;
        int unsigned r;
        flags = "-+ #0";
        convs = "diuxXsScpfge%";
        push_str("%");
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            push_position();
            push_str("$");
        end
        else if (r < 48)
            push_position();
        if ($urandom_range(0, 99) < 40)
            fmt_chars.push_back(flags[$urandom_range(0, 4)]);
        r = $urandom_range(0, 99);
        if (r < 30)
            push_num($urandom_range(1, 99));
        else if (r < 45)
            push_str("*");
        else if (r < 55)
        begin
            push_str("*");
            push_position();
            push_str("$");
        end
        else if (r < 60)
        begin
            push_str("*");
            push_num($urandom_range(0, 999));
        end
        if ($urandom_range(0, 99) < 30)
        begin
            push_str(".");
            r = $urandom_range(0, 99);
            if (r < 40)
                push_num($urandom_range(0, 99));
            else if (r < 60)
                push_str("*");
            else if (r < 80)
            begin
                push_str("*");
                push_position();
                push_str("$");
            end
        end
        case ($urandom_range(0, 5))
            1: push_str("h");
            2: push_str("hh");
            3: push_str("l");
            4: push_str("ll");
            5: push_str("L");
            default: ;
        endcase
        r = $urandom_range(0, 99);
        if (r < 65)
            push_str("n");
        else if (r < 85)
            fmt_chars.push_back(convs[$urandom_range(0, convs.len() - 1)]);
        else
            fmt_chars.push_back(8'($urandom_range(1, 255)));
    endfunction

    function automatic void push_random_string();
        string spec_chars;
        int unsigned cut;
        spec_chars = "%$*.0123456789hlLn-+ #";
        if ($urandom_range(0, 99) < 8)
        begin
            // noise rich in spec characters
            repeat ($urandom_range(1, 12))
                if ($urandom_range(0, 1) == 0)
                    fmt_chars.push_back(spec_chars[$urandom_range(0, spec_chars.len() - 1)]);
                else
                    fmt_chars.push_back(8'($urandom_range(1, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 5))
            begin
                repeat ($urandom_range(0, 3))
                    fmt_chars.push_back(8'($urandom_range(1, 255)));
                push_spec();
            end
            repeat ($urandom_range(0, 2))
                fmt_chars.push_back(8'($urandom_range(1, 255)));
            // some strings stop in the middle of a spec
            if ($urandom_range(0, 99) < 12)
            begin
                cut = $urandom_range(1, fmt_chars.size());
                fmt_chars = fmt_chars[0:cut-1];
            end
        end
    endfunction

    // sends the queued string, last set on its final character
    task automatic send_string();
        for (int i = 0; i < fmt_chars.size(); i++)
        begin
            @(negedge clk);
            while (!calm && $urandom_range(0, 99) < 19)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= fmt_chars[i];
            s_tlast  <= (i == fmt_chars.size() - 1);
            do
                @(posedge clk);
            while (!s_tready);
        end
        fmt_chars.delete();
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_sizes(input logic [3:0] i_b, input logic [3:0] s_b,
                             input logic [3:0] l_b, input logic [3:0] ll_b);
        write_reg(REG_INT_BYTES, i_b);
        write_reg(REG_SHORT_BYTES, s_b);
        write_reg(REG_LONG_BYTES, l_b);
        write_reg(REG_LONG_LONG_BYTES, ll_b);
    endtask

    initial
    begin
        int sent;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        hold_go  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // saturated position, l modifier, then a plain %n: mixed, two items on one character
        push_str("%99999$ln%n");
        send_string();
        // extreme bytes, lone leading zero as flag, star run without '$', hh
        push_str("\001%0n%*1%hhn\377");
        send_string();
        // zero position, h, positional star precision, string ends after L
        push_str("%0$hn%.*4$L");
        send_string();
        // string ends inside a star run
        push_str("%*3");
        send_string();

        // long result hold-off while the input keeps coming
        drain();
        hold_go = 1'b1;
        calm = 1'b1;
        repeat (40) push_str("%n");
        send_string();
        calm = 1'b0;

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0: set_sizes(4'd8, 4'd1, 4'd8, 4'd1);
                1: set_sizes(4'd1, 4'd8, 4'd1, 4'd8);
                default: set_sizes(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)),
                                   4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)));
            endcase
            calm = (ph == 2);
            sent = 0;
            while (sent < 250)
            begin
                push_random_string();
                sent += fmt_chars.size();
                send_string();
            end
        end
        calm = 1'b0;

        drain();
        if (mismatches == 0)
            $display("PASS format_spec_pointer_arg_scanner");
        else
            $display("FAIL format_spec_pointer_arg_scanner");
        $finish;
    end

endmodule
